[src/ooseq_pkg.sv]
package ooseq_pkg;

   localparam int MAX_STEPS = 16;
   localparam int INDEX_W   = 4;
   localparam int STEP_W    = 5;
   localparam int DUTY_W    = 10;
   localparam int TIME_W    = 32;
   localparam int COUNT_W   = 8;

   localparam logic [DUTY_W-1:0] DUTY_RESET = 10'd1023;

   localparam logic [1:0] OP_TICK  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_START = 2'd2;
   localparam logic [1:0] OP_STOP  = 2'd3;

   typedef struct packed {
      logic [1:0]         opcode;
      logic [TIME_W-1:0]  now_ms;
      logic [INDEX_W-1:0] entry_index;
      logic [TIME_W-1:0]  duration_ms;
      logic [COUNT_W-1:0] step_count;
   } req_type;

   typedef struct packed {
      logic [DUTY_W-1:0] drive_duty;
      logic              is_active;
      logic [STEP_W-1:0] current_step;
   } rsp_type;

endpackage

[src/ooseq_engine.sv]
module ooseq_engine (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            fire,
   input  ooseq_pkg::req_type              item,
   input  logic [ooseq_pkg::DUTY_W-1:0]    on_duty,
   output ooseq_pkg::rsp_type              result
);

   logic [ooseq_pkg::TIME_W-1:0] duration_table_ff [ooseq_pkg::MAX_STEPS];

   logic [ooseq_pkg::STEP_W-1:0] steps_in_use_ff, steps_in_use_in;
   logic [ooseq_pkg::STEP_W-1:0] step_pointer_ff, step_pointer_in;
   logic [ooseq_pkg::TIME_W-1:0] step_start_ms_ff, step_start_ms_in;
   logic                         phase_on_ff, phase_on_in;
   logic                         running_ff, running_in;

   logic [ooseq_pkg::TIME_W-1:0] elapsed;
   logic [ooseq_pkg::TIME_W-1:0] cur_duration;
   logic [ooseq_pkg::STEP_W-1:0] pointer_inc;
   logic [ooseq_pkg::STEP_W-1:0] clamped_count;
   logic                         table_write;

   assign elapsed      = item.now_ms - step_start_ms_ff;
   assign cur_duration = duration_table_ff[step_pointer_ff[ooseq_pkg::INDEX_W-1:0]];
   assign pointer_inc  = step_pointer_ff + ooseq_pkg::STEP_W'(1);
   assign clamped_count = (item.step_count > ooseq_pkg::COUNT_W'(ooseq_pkg::MAX_STEPS))
                        ? ooseq_pkg::STEP_W'(ooseq_pkg::MAX_STEPS)
                        : item.step_count[ooseq_pkg::STEP_W-1:0];

   always_comb begin
      steps_in_use_in  = steps_in_use_ff;
      step_pointer_in  = step_pointer_ff;
      step_start_ms_in = step_start_ms_ff;
      phase_on_in      = phase_on_ff;
      running_in       = running_ff;
      table_write      = 1'b0;
      unique case (item.opcode)
         ooseq_pkg::OP_TICK: begin
            if (running_ff && (elapsed >= cur_duration)) begin
               step_pointer_in = pointer_inc;
               if (pointer_inc >= steps_in_use_ff) begin
                  running_in = 1'b0;
               end else begin
                  phase_on_in      = ~phase_on_ff;
                  step_start_ms_in = item.now_ms;
               end
            end
         end
         ooseq_pkg::OP_WRITE: begin
            running_in  = 1'b0;
            table_write = 1'b1;
         end
         ooseq_pkg::OP_START: begin
            if (item.step_count != '0) begin
               steps_in_use_in  = clamped_count;
               step_pointer_in  = '0;
               step_start_ms_in = item.now_ms;
               phase_on_in      = 1'b1;
               running_in       = 1'b1;
            end
         end
         ooseq_pkg::OP_STOP: begin
            running_in = 1'b0;
         end
         default: begin
            running_in = running_ff;
         end
      endcase
   end

   always_comb begin
      result.drive_duty   = (running_in && phase_on_in) ? on_duty : '0;
      result.is_active    = running_in;
      result.current_step = step_pointer_in;
   end

   always_ff @(posedge clock) begin
      if (fire && table_write) begin
         duration_table_ff[item.entry_index] <= item.duration_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         steps_in_use_ff  <= '0;
         step_pointer_ff  <= '0;
         step_start_ms_ff <= '0;
         phase_on_ff      <= 1'b0;
         running_ff       <= 1'b0;
      end else if (fire) begin
         steps_in_use_ff  <= steps_in_use_in;
         step_pointer_ff  <= step_pointer_in;
         step_start_ms_ff <= step_start_ms_in;
         phase_on_ff      <= phase_on_in;
         running_ff       <= running_in;
      end
   end

endmodule

[src/on_off_pattern_sequencer_core.sv]
// an accepted transaction goes from the input register to the result register
// throughput: one transaction per cycle unless stalled; the combinational
// pattern state update between the input and result registers sets this rate
// reset: clears the pattern state, both pipeline valids and sets on_duty to 1023
// reset: the duration table holds unknown values until written
module on_off_pattern_sequencer_core (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_stall,
   input  ooseq_pkg::req_type           req_payload,
   output logic                         rsp_valid,
   input  logic                         rsp_stall,
   output ooseq_pkg::rsp_type           rsp_payload,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [ooseq_pkg::DUTY_W-1:0] csr_data
);

   logic                         in_valid_ff, in_valid_in;
   ooseq_pkg::req_type           in_item_ff;
   logic                         rsp_valid_ff, rsp_valid_in;
   ooseq_pkg::rsp_type           rsp_item_ff;
   logic [ooseq_pkg::DUTY_W-1:0] on_duty_ff;
   logic                         out_ready;
   logic                         process;
   logic                         req_take;
   ooseq_pkg::rsp_type           engine_result;

   assign out_ready    = ~rsp_valid_ff | ~rsp_stall;
   assign process      = in_valid_ff & out_ready;
   assign req_stall    = in_valid_ff & ~out_ready;
   assign req_take     = req_valid & ~req_stall;
   assign in_valid_in  = req_stall ? in_valid_ff : req_valid;
   assign rsp_valid_in = out_ready ? process : rsp_valid_ff;
   assign csr_ready    = 1'b1;
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_payload  = rsp_item_ff;

   ooseq_engine u_engine (
      .clock   (clock),
      .reset   (reset),
      .fire    (process),
      .item    (in_item_ff),
      .on_duty (on_duty_ff),
      .result  (engine_result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         on_duty_ff   <= ooseq_pkg::DUTY_RESET;
      end else begin
         in_valid_ff  <= in_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid && csr_ready) begin
            on_duty_ff <= csr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_item_ff <= req_payload;
      end
      if (process) begin
         rsp_item_ff <= engine_result;
      end
   end

   a_stall_only_when_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (in_valid_ff && rsp_valid_ff))
      else $error("input stalled without a blocked result");

   a_take_fills_input: assert property (@(posedge clock) disable iff (reset)
      req_take |=> in_valid_ff)
      else $error("accepted transaction lost from input register");

   a_process_gives_result: assert property (@(posedge clock) disable iff (reset)
      process |=> rsp_valid_ff)
      else $error("processed transaction produced no result");

   a_active_step_in_range: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_item_ff.is_active)
         |-> (rsp_item_ff.current_step < ooseq_pkg::STEP_W'(ooseq_pkg::MAX_STEPS)))
      else $error("active pattern step out of range");

   a_duty_needs_active: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_item_ff.is_active) |-> (rsp_item_ff.drive_duty == '0))
      else $error("duty driven while pattern stopped");

endmodule
